/* rtl/brms_pkg.sv */
package brms_pkg;

  // Item opcodes.
  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_READ       = 1'b1;

  // Accumulate modes; the unused code behaves as plain sample power.
  localparam logic [1:0] MODE_POWER     = 2'd0;
  localparam logic [1:0] MODE_REF_POWER = 2'd1;
  localparam logic [1:0] MODE_REF_SUM   = 2'd2;

  // Register byte addresses.
  localparam logic [1:0] ADDR_MODE = 2'd0;

  // Result limits.
  localparam logic [25:0]        RMS_MAX  = 26'h3FF_FFFF;
  localparam logic signed [24:0] MEAN_MAX = 25'sh0FF_FFFF;
  localparam logic signed [24:0] MEAN_MIN = 25'sh100_0000;

  // One table entry, all four statistics side by side.
  typedef struct packed {
    logic signed [63:0] clean_sum;
    logic [31:0]        clean_count;
    logic signed [63:0] total_sum;
    logic [31:0]        total_count;
  } entry_t;

  // Request to the division and square root unit.
  typedef struct packed {
    logic [63:0] mag;
    logic [31:0] cnt;
    logic        neg;
  } stats_req_t;

  // Answer of the division and square root unit.
  typedef struct packed {
    logic [25:0]        rms;
    logic signed [24:0] mean;
  } stats_res_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ISSUE,
    S_SUM,
    S_EXEC,
    S_STAT
  } state_e;

  typedef enum logic [1:0] {
    T_IDLE,
    T_DIV,
    T_SQRT
  } stats_state_e;

  // Signed add that saturates at the 64-bit limits.
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] s,
                                                 input logic signed [35:0] d);
    logic signed [64:0] t;
    t = 65'(s) + 65'(d);
    if (t[64] != t[63]) begin
      sat_add = t[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add = t[63:0];
    end
  endfunction

  // Count step of two that saturates at all ones.
  function automatic logic [31:0] cnt_add2(input logic [31:0] c);
    cnt_add2 = (c >= 32'hFFFF_FFFD) ? 32'hFFFF_FFFF : c + 32'd2;
  endfunction

endpackage

/* rtl/baseline_rms_accumulator.sv */
// Channel   Direction  Ports                                         Handshake
// command   in         opcode_i, antenna_*_i, field_index_i,        start_i, busy_o
//                      sample_*_i, ref_*_i, flagged_i
// result    out        rms_value_o, mean_value_o, used_count_o,     done_o
//                      used_all_samples_o, entry_empty_o
// config    in/out     psel, penable, pwrite, paddr, pwdata,        pready
//                      prdata
//
// An accumulate item passes through the memory read with the squares, the sum, the write back,
// and the idle state that takes the next item.
// A read item on an empty entry finishes without the statistics unit; otherwise the 80-step divider
// settles it (negative sum or saturated RMS) or hands it on to the 26-step square root.
// After reset a clearing pass zeroes the memory, one entry per cycle;
// busy_o stays high meanwhile.
// Each result shows for one cycle on done_o; the receiver cannot stall it.
module baseline_rms_accumulator import brms_pkg::*; #(
  parameter int ANTENNAS = 64,
  parameter int FIELDS   = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               opcode_i,
  input  logic [5:0]         antenna_a_i,
  input  logic [5:0]         antenna_b_i,
  input  logic [1:0]         field_index_i,
  input  logic signed [15:0] sample_re_i,
  input  logic signed [15:0] sample_im_i,
  input  logic signed [15:0] ref_re_i,
  input  logic signed [15:0] ref_im_i,
  input  logic               flagged_i,
  output logic               done_o,
  output logic [25:0]        rms_value_o,
  output logic signed [24:0] mean_value_o,
  output logic [31:0]        used_count_o,
  output logic               used_all_samples_o,
  output logic               entry_empty_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int Entries = ANTENNAS * ANTENNAS * FIELDS;
  localparam int AddrW   = $clog2(Entries);

  state_e state_q, state_d;
  logic [AddrW-1:0] clr_addr_q;
  logic [1:0]       mode_q;

  logic               op_q, flag_q;
  logic [5:0]         a_q, b_q;
  logic [1:0]         f_q;
  logic signed [15:0] re_q, im_q, rr_q, ri_q;
  logic signed [33:0] p_re_q, p_im_q;
  logic signed [17:0] dsum_q;
  logic signed [35:0] delta_q;

  logic        neg_q, all_q;
  logic [31:0] cnt_q;

  logic               done_q;
  logic [25:0]        rms_q;
  logic signed [24:0] mean_q;
  logic [31:0]        used_q;
  logic               used_all_q, empty_q;

  logic               accept;
  logic [31:0]        idx_full;
  logic [AddrW-1:0]   idx;
  logic               ent_valid;
  logic               diff_mode;
  logic signed [16:0] pr, pi;
  entry_t             rd_ent, wr_ent;
  logic               ram_we, ram_re;
  logic [AddrW-1:0]   ram_waddr;
  logic               use_clean;
  logic signed [63:0] sel_sum;
  logic [31:0]        sel_cnt;
  logic               stats_start, stats_done;
  stats_req_t         stats_req;
  stats_res_t         stats_res;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  // Entry address and range check from the captured item.
  assign idx_full  = (32'(f_q) * 32'(ANTENNAS) + 32'(b_q)) * 32'(ANTENNAS) + 32'(a_q);
  assign idx       = idx_full[AddrW-1:0];
  assign ent_valid = (32'(a_q) < 32'(ANTENNAS)) && (32'(b_q) < 32'(ANTENNAS)) &&
                     (32'(f_q) < 32'(FIELDS));

  // Differences or plain sample parts feed the squares.
  assign diff_mode = (mode_q == MODE_REF_POWER) || (mode_q == MODE_REF_SUM);
  assign pr = diff_mode ? (17'(rr_q) - 17'(re_q)) : 17'(re_q);
  assign pi = diff_mode ? (17'(ri_q) - 17'(im_q)) : 17'(im_q);

  // Statistics selection for a read.
  assign use_clean = ent_valid && (rd_ent.clean_count != 32'd0);
  assign sel_sum   = !ent_valid ? 64'sd0 :
                     (use_clean ? rd_ent.clean_sum : rd_ent.total_sum);
  assign sel_cnt   = !ent_valid ? 32'd0 :
                     (use_clean ? rd_ent.clean_count : rd_ent.total_count);

  assign stats_start   = (state_q == S_EXEC) && (op_q == OP_READ) && (sel_cnt != 32'd0);
  assign stats_req.mag = sel_sum[63] ? (64'd0 - 64'(sel_sum)) : 64'(sel_sum);
  assign stats_req.cnt = sel_cnt;
  assign stats_req.neg = sel_sum[63];

  // Updated entry for an accumulate.
  always_comb begin
    wr_ent = rd_ent;
    wr_ent.total_sum   = sat_add(rd_ent.total_sum, delta_q);
    wr_ent.total_count = cnt_add2(rd_ent.total_count);
    if (!flag_q) begin
      wr_ent.clean_sum   = sat_add(rd_ent.clean_sum, delta_q);
      wr_ent.clean_count = cnt_add2(rd_ent.clean_count);
    end
    if (state_q == S_CLEAR) begin
      wr_ent = '0;
    end
  end

  assign ram_re    = (state_q == S_ISSUE);
  assign ram_we    = (state_q == S_CLEAR) ||
                     ((state_q == S_EXEC) && (op_q == OP_ACCUMULATE) && ent_valid);
  assign ram_waddr = (state_q == S_CLEAR) ? clr_addr_q : idx;

  brms_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(Entries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wr_ent),
    .re_i   (ram_re),
    .raddr_i(idx),
    .rdata_o(rd_ent)
  );

  brms_stats u_stats (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(stats_start),
    .req_i  (stats_req),
    .done_o (stats_done),
    .res_o  (stats_res)
  );

  // Sequencer for one item at a time.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_addr_q == AddrW'(Entries - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: state_d = S_SUM;
      S_SUM:   state_d = S_EXEC;
      S_EXEC: begin
        state_d = stats_start ? S_STAT : S_IDLE;
      end
      S_STAT: begin
        if (stats_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state, configuration and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_addr_q <= '0;
      mode_q     <= MODE_POWER;
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
      end
      if (psel && penable && pwrite && (paddr == ADDR_MODE)) begin
        mode_q <= pwdata[1:0];
      end
      done_q <= ((state_q == S_EXEC) && (op_q == OP_READ) && !stats_start) ||
                ((state_q == S_STAT) && stats_done);
    end
  end

  // Item capture and arithmetic pipeline.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      a_q    <= antenna_a_i;
      b_q    <= antenna_b_i;
      f_q    <= field_index_i;
      re_q   <= sample_re_i;
      im_q   <= sample_im_i;
      rr_q   <= ref_re_i;
      ri_q   <= ref_im_i;
      flag_q <= flagged_i;
    end
    if (state_q == S_ISSUE) begin
      p_re_q <= pr * pr;
      p_im_q <= pi * pi;
      dsum_q <= 18'(pr) + 18'(pi);
    end
    if (state_q == S_SUM) begin
      delta_q <= (mode_q == MODE_REF_SUM) ? 36'(dsum_q) : (36'(p_re_q) + 36'(p_im_q));
    end
    if (state_q == S_EXEC) begin
      cnt_q <= sel_cnt;
      all_q <= !use_clean;
      neg_q <= sel_sum[63];
    end
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_EXEC) && (op_q == OP_READ) && !stats_start) begin
      rms_q      <= '0;
      mean_q     <= '0;
      used_q     <= sel_cnt;
      used_all_q <= !use_clean;
      empty_q    <= 1'b1;
    end else if ((state_q == S_STAT) && stats_done) begin
      rms_q      <= neg_q ? 26'd0 : stats_res.rms;
      mean_q     <= stats_res.mean;
      used_q     <= cnt_q;
      used_all_q <= all_q;
      empty_q    <= 1'b0;
    end
  end

  assign done_o             = done_q;
  assign rms_value_o        = rms_q;
  assign mean_value_o       = mean_q;
  assign used_count_o       = used_q;
  assign used_all_samples_o = used_all_q;
  assign entry_empty_o      = empty_q;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MODE) ? {30'd0, mode_q} : 32'd0;

endmodule

/* rtl/brms_ram.sv */
module brms_ram #(
  parameter int WIDTH = 192,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/brms_stats.sv */
module brms_stats import brms_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  stats_req_t req_i,
  output logic       done_o,
  output stats_res_t res_o
);

  stats_state_e st_q, st_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [79:0] dvd_q, dvd_d;
  logic [6:0]  step_q, step_d;
  logic        neg_q, neg_d;
  logic [51:0] sq_src_q, sq_src_d;
  logic [27:0] sq_rem_q, sq_rem_d;
  logic [25:0] sq_res_q, sq_res_d;
  logic        done_q, done_d;
  stats_res_t  res_q, res_d;

  logic [32:0] div_t;
  logic [29:0] sq_t;
  logic [29:0] sq_trial;
  logic        big;
  logic [23:0] m24;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= T_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    rem_q    <= rem_d;
    dvd_q    <= dvd_d;
    step_q   <= step_d;
    neg_q    <= neg_d;
    sq_src_q <= sq_src_d;
    sq_rem_q <= sq_rem_d;
    sq_res_q <= sq_res_d;
    res_q    <= res_d;
  end

  // Restoring division of mag * 2^16 by the count, one quotient bit per cycle,
  // then, for a positive sum below the RMS limit, a digit-by-digit square root, one result bit per cycle.
  always_comb begin
    st_d     = st_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    dvd_d    = dvd_q;
    step_d   = step_q;
    neg_d    = neg_q;
    sq_src_d = sq_src_q;
    sq_rem_d = sq_rem_q;
    sq_res_d = sq_res_q;
    res_d    = res_q;
    done_d   = 1'b0;
    div_t    = {rem_q, dvd_q[79]};
    sq_t     = {sq_rem_q, sq_src_q[51:50]};
    sq_trial = {2'b00, sq_res_q, 2'b01};
    big      = 1'b0;
    m24      = '0;
    unique case (st_q)
      T_IDLE: begin
        if (start_i) begin
          cnt_d  = req_i.cnt;
          rem_d  = '0;
          dvd_d  = {req_i.mag, 16'd0};
          neg_d  = req_i.neg;
          step_d = 7'd79;
          st_d   = T_DIV;
        end
      end
      T_DIV: begin
        if (div_t >= {1'b0, cnt_q}) begin
          rem_d = 32'(div_t - {1'b0, cnt_q});
          dvd_d = {dvd_q[78:0], 1'b1};
        end else begin
          rem_d = div_t[31:0];
          dvd_d = {dvd_q[78:0], 1'b0};
        end
        step_d = step_q - 7'd1;
        if (step_q == 7'd0) begin
          // Mean is the quotient without its eight lowest bits.
          big = |dvd_d[79:32];
          m24 = dvd_d[31:8];
          if (neg_q) begin
            res_d.mean = big ? MEAN_MIN : -$signed({1'b0, m24});
          end else begin
            res_d.mean = big ? MEAN_MAX : $signed({1'b0, m24});
          end
          if (neg_q) begin
            res_d.rms = '0;
            done_d    = 1'b1;
            st_d      = T_IDLE;
          end else if (|dvd_d[79:52]) begin
            res_d.rms = RMS_MAX;
            done_d    = 1'b1;
            st_d      = T_IDLE;
          end else begin
            sq_src_d = dvd_d[51:0];
            sq_rem_d = '0;
            sq_res_d = '0;
            step_d   = 7'd25;
            st_d     = T_SQRT;
          end
        end
      end
      T_SQRT: begin
        if (sq_t >= sq_trial) begin
          sq_rem_d = 28'(sq_t - sq_trial);
          sq_res_d = {sq_res_q[24:0], 1'b1};
        end else begin
          sq_rem_d = sq_t[27:0];
          sq_res_d = {sq_res_q[24:0], 1'b0};
        end
        sq_src_d = {sq_src_q[49:0], 2'b00};
        step_d   = step_q - 7'd1;
        if (step_q == 7'd0) begin
          res_d.rms = sq_res_d;
          done_d    = 1'b1;
          st_d      = T_IDLE;
        end
      end
      default: st_d = T_IDLE;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* bench/tb_baseline_rms_accumulator.sv */
module tb_baseline_rms_accumulator import brms_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int SETTLE_CYCLES  = 150;
  localparam int ITEMS_PER_PHASE = 450;

  typedef struct packed {
    logic [25:0]        rms;
    logic signed [24:0] mean;
    logic [31:0]        cnt;
    logic               all;
    logic               empty;
  } stats_t;

  typedef struct {
    logic               is_cfg;
    logic [1:0]         mode;
    logic               op;
    logic [5:0]         a;
    logic [5:0]         b;
    logic [1:0]         f;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic signed [15:0] rr;
    logic signed [15:0] ri;
    logic               flag;
    logic               has_exp;
    stats_t             exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic opcode_i = OP_ACCUMULATE;
  logic [5:0] antenna_a_i = '0;
  logic [5:0] antenna_b_i = '0;
  logic [1:0] field_index_i = '0;
  logic signed [15:0] sample_re_i = '0;
  logic signed [15:0] sample_im_i = '0;
  logic signed [15:0] ref_re_i = '0;
  logic signed [15:0] ref_im_i = '0;
  logic flagged_i = 1'b0;
  logic done_o;
  logic [25:0] rms_value_o;
  logic signed [24:0] mean_value_o;
  logic [31:0] used_count_o;
  logic used_all_samples_o;
  logic entry_empty_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  baseline_rms_accumulator dut (.*);

  always #6 clk_i = ~clk_i;

  // Shadow copy of the statistics table, kept sparse.
  longint          clean_sum_m[int];
  longint unsigned clean_cnt_m[int];
  longint          total_sum_m[int];
  longint unsigned total_cnt_m[int];
  logic [1:0]      mode_m = MODE_POWER;

  stats_t pending_stats[$];
  int errors = 0;
  int checked = 0;
  int accepted = 0;
  int reads_sent = 0;
  int idle_cycles = 0;
  int idle_pct = 0;

  function automatic longint sat_sum(longint s, longint d);
    logic signed [64:0] t;
    t = 65'(s) + 65'(d);
    if (t[64] != t[63]) return t[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return t[63:0];
  endfunction

  function automatic longint unsigned count_step(longint unsigned c);
    return (c >= 64'hFFFF_FFFD) ? 64'hFFFF_FFFF : c + 2;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  // Adds one sample to the shadow entry under the current mode.
  function automatic void accumulate_sample(row_t r);
    int key;
    longint re, im, dr, di, d;
    key = int'({r.f, r.b, r.a});
    re = r.re;
    im = r.im;
    dr = longint'(r.rr) - re;
    di = longint'(r.ri) - im;
    case (mode_m)
      MODE_REF_POWER: d = dr * dr + di * di;
      MODE_REF_SUM:   d = dr + di;
      default:        d = re * re + im * im;
    endcase
    if (!total_sum_m.exists(key)) begin
      total_sum_m[key] = 0;
      total_cnt_m[key] = 0;
      clean_sum_m[key] = 0;
      clean_cnt_m[key] = 0;
    end
    total_sum_m[key] = sat_sum(total_sum_m[key], d);
    total_cnt_m[key] = count_step(total_cnt_m[key]);
    if (!r.flag) begin
      clean_sum_m[key] = sat_sum(clean_sum_m[key], d);
      clean_cnt_m[key] = count_step(clean_cnt_m[key]);
    end
  endfunction

  // Mean and RMS of one entry, clean totals first.
  function automatic stats_t entry_stats(row_t r);
    stats_t s;
    int key;
    longint sum;
    longint unsigned cnt, mag, q, rem, m, x, root;
    key = int'({r.f, r.b, r.a});
    sum = 0;
    cnt = 0;
    s = '0;
    s.all = 1'b1;
    if (total_sum_m.exists(key)) begin
      if (clean_cnt_m[key] != 0) begin
        sum = clean_sum_m[key];
        cnt = clean_cnt_m[key];
        s.all = 1'b0;
      end else begin
        sum = total_sum_m[key];
        cnt = total_cnt_m[key];
      end
    end
    if (cnt != 0) begin
      mag = (sum < 0) ? 64'd0 - longint'(sum) : sum;
      q = mag / cnt;
      rem = mag % cnt;
      m = (q >= (64'd1 << 40)) ? (64'd1 << 48) : q * 256 + (rem * 256) / cnt;
      if (sum < 0) begin
        s.mean = (m >= 64'd16777216) ? MEAN_MIN : -25'(m);
      end else begin
        s.mean = (m > 64'd16777215) ? MEAN_MAX : 25'(m);
        x = (q >= (64'd1 << 47)) ? (64'd1 << 63) : q * 65536 + (rem * 65536) / cnt;
        root = int_sqrt(x);
        s.rms = (root > 64'(RMS_MAX)) ? RMS_MAX : 26'(root);
      end
    end
    s.cnt = cnt[31:0];
    s.empty = (cnt == 0);
    return s;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Result checker: every done strobe is compared with the oldest expectation.
  always @(posedge clk_i) begin
    stats_t want;
    if (done_o) begin
      if (pending_stats.size() == 0) begin
        $display("MISMATCH unexpected result, rms %0d mean %0d", rms_value_o, mean_value_o);
        errors++;
      end else begin
        want = pending_stats.pop_front();
        checked++;
        if (rms_value_o !== want.rms) report_mismatch("rms_value", rms_value_o, want.rms);
        if (mean_value_o !== want.mean)
          report_mismatch("mean_value", mean_value_o, want.mean);
        if (used_count_o !== want.cnt) report_mismatch("used_count", used_count_o, want.cnt);
        if (used_all_samples_o !== want.all)
          report_mismatch("used_all_samples", used_all_samples_o, want.all);
        if (entry_empty_o !== want.empty)
          report_mismatch("entry_empty", entry_empty_o, want.empty);
      end
    end
  end

  // Watchdog on cycles without any accepted item, register access or result.
  always @(posedge clk_i) begin
    if (done_o || (start_i && !busy_o) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d quiet cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Waits until every read has answered and the block has settled.
  task automatic drain_block();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic write_mode(logic [1:0] mode);
    drain_block();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_MODE;
    pwdata <= 32'(mode);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    mode_m = mode;
  endtask

  // Drives one item, waits for acceptance and records what it should produce.
  task automatic send_item(row_t r);
    int gap;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    opcode_i <= r.op;
    antenna_a_i <= r.a;
    antenna_b_i <= r.b;
    field_index_i <= r.f;
    sample_re_i <= r.re;
    sample_im_i <= r.im;
    ref_re_i <= r.rr;
    ref_im_i <= r.ri;
    flagged_i <= r.flag;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    accepted++;
    if (r.op == OP_READ) begin
      reads_sent++;
      pending_stats.push_back(r.has_exp ? r.exp : entry_stats(r));
    end else begin
      accumulate_sample(r);
    end
  endtask

  function automatic row_t item_row(logic op, int a, int b, int f, int re, int im,
                                    int rr, int ri, logic flag);
    row_t r;
    r = '{default: '0};
    r.op = op;
    r.a = 6'(a);
    r.b = 6'(b);
    r.f = 2'(f);
    r.re = 16'(re);
    r.im = 16'(im);
    r.rr = 16'(rr);
    r.ri = 16'(ri);
    r.flag = flag;
    return r;
  endfunction

  function automatic row_t mode_row(logic [1:0] mode);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.mode = mode;
    return r;
  endfunction

  function automatic logic signed [15:0] rand_part();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'(int'($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  row_t dir_tbl[$];
  int hot_keys[12];

  initial begin
    row_t r;
    int key;

    // Directed rows; expectations typed in where they are obvious.
    r = item_row(OP_READ, 5, 5, 1, 0, 0, 0, 0, 0);
    r.has_exp = 1;
    r.exp = '{rms: 0, mean: 0, cnt: 0, all: 1, empty: 1};
    dir_tbl.push_back(r);
    dir_tbl.push_back(item_row(OP_ACCUMULATE, 63, 63, 3, -32768, -32768, 0, 0, 0));
    r = item_row(OP_READ, 63, 63, 3, 0, 0, 0, 0, 0);
    r.has_exp = 1;
    r.exp = '{rms: 26'd8388608, mean: MEAN_MAX, cnt: 2, all: 0, empty: 0};
    dir_tbl.push_back(r);
    // An entry with flagged samples only falls back to the total sums.
    dir_tbl.push_back(item_row(OP_ACCUMULATE, 1, 2, 0, 3, 4, 0, 0, 1));
    r = item_row(OP_READ, 1, 2, 0, 0, 0, 0, 0, 0);
    r.has_exp = 1;
    r.exp = '{rms: 905, mean: 3200, cnt: 2, all: 1, empty: 0};
    dir_tbl.push_back(r);
    dir_tbl.push_back(item_row(OP_ACCUMULATE, 0, 0, 0, 32767, 32767, 0, 0, 0));
    dir_tbl.push_back(item_row(OP_ACCUMULATE, 0, 0, 0, 0, 0, 0, 0, 1));
    dir_tbl.push_back(item_row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tbl.push_back(mode_row(MODE_REF_POWER));
    dir_tbl.push_back(item_row(OP_ACCUMULATE, 10, 20, 2, -32768, 32767, 32767, -32768, 0));
    dir_tbl.push_back(item_row(OP_ACCUMULATE, 10, 20, 2, 0, 0, -32768, -32768, 1));
    dir_tbl.push_back(item_row(OP_READ, 10, 20, 2, 0, 0, 0, 0, 0));
    // Difference sum mode drives the sum negative, so the RMS reads zero.
    dir_tbl.push_back(mode_row(MODE_REF_SUM));
    dir_tbl.push_back(item_row(OP_ACCUMULATE, 7, 7, 1, 32767, 32767, -32768, -32768, 0));
    dir_tbl.push_back(item_row(OP_ACCUMULATE, 7, 7, 1, 1, -1, 0, 0, 1));
    dir_tbl.push_back(item_row(OP_READ, 7, 7, 1, 0, 0, 0, 0, 0));
    dir_tbl.push_back(item_row(OP_ACCUMULATE, 7, 7, 1, -32768, -32768, 32767, 32767, 0));
    dir_tbl.push_back(item_row(OP_READ, 7, 7, 1, 0, 0, 0, 0, 0));
    // The unused mode code behaves as plain sample power.
    dir_tbl.push_back(mode_row(2'd3));
    dir_tbl.push_back(item_row(OP_ACCUMULATE, 3, 0, 0, 1, 0, 0, 0, 0));
    r = item_row(OP_READ, 3, 0, 0, 0, 0, 0, 0, 0);
    r.has_exp = 1;
    r.exp = '{rms: 181, mean: 128, cnt: 2, all: 0, empty: 0};
    dir_tbl.push_back(r);

    foreach (hot_keys[i]) hot_keys[i] = $urandom_range(16383);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg) write_mode(dir_tbl[i].mode);
      else send_item(dir_tbl[i]);
    end

    // Random phases, one per mode, each with its own sender idling.
    for (int ph = 0; ph < 4; ph++) begin
      write_mode(2'(ph));
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 81;
        2: idle_pct = 0;
        default: idle_pct = 38;
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        key = ($urandom_range(99) < 80) ? hot_keys[$urandom_range(11)] : $urandom_range(16383);
        r = item_row(($urandom_range(99) < 15) ? OP_READ : OP_ACCUMULATE,
                     key[5:0], key[11:6], key[13:12],
                     rand_part(), rand_part(), rand_part(), rand_part(),
                     $urandom_range(99) < 25);
        send_item(r);
        // Occasionally toggles between bursts with no idling at all and idling at 50 percent.
        if ($urandom_range(99) == 0) idle_pct = (idle_pct == 0) ? 50 : 0;
      end
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d items (%0d reads) over four accumulate modes.", accepted, reads_sent);
    $display("Checked %0d statistics results, %0d mismatches.", checked, errors);
    if (errors == 0 && pending_stats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
